@@ design/graph_bfs_dfs_traversal_defines.svh @@
// ----------------------------------------------------------------------------
// graph traversal assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef GRAPH_BFS_DFS_TRAVERSAL_DEFINES_SVH
`define GRAPH_BFS_DFS_TRAVERSAL_DEFINES_SVH

// same-cycle implication, reset masked
`define GBT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gbt check failed");

// next-cycle implication, reset masked
`define GBT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gbt check failed");

`endif

@@ design/gbt_pkg.sv @@
// ----------------------------------------------------------------------------
// gbt_pkg
// shared constants, codes and types of the graph traversal block
// ----------------------------------------------------------------------------
package gbt_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int MAX_ENTRIES  = 512;

  localparam int VIDX_W = $clog2(MAX_VERTICES);
  localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
  localparam int EIDX_W = $clog2(MAX_ENTRIES);
  localparam int EPTR_W = $clog2(MAX_ENTRIES + 1);
  localparam int CFG_W  = 7;
  localparam int VTX_W  = 6;
  localparam int ST_W   = 2;
  localparam int MODE_W = 2;

  localparam logic [EPTR_W-1:0] NO_ENTRY = EPTR_W'(MAX_ENTRIES);
  localparam logic [CFG_W-1:0]  COUNT_RESET = CFG_W'(64);

  typedef enum logic [MODE_W-1:0] {
    MODE_ADD = 2'd0,
    MODE_CLR = 2'd1,
    MODE_BFS = 2'd2,
    MODE_DFS = 2'd3
  } mode_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK   = 2'd0,
    ST_BAD  = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef struct packed {
    logic [VTX_W-1:0] vertex;
    logic [ST_W-1:0]  status;
    logic             last;
  } res_t;

  function automatic logic is_null(input logic [EPTR_W-1:0] p);
    return p >= NO_ENTRY;
  endfunction

endpackage

@@ design/graph_bfs_dfs_traversal.sv @@
// ----------------------------------------------------------------------------
// graph_bfs_dfs_traversal
// adjacency-list graph store with breadth-first and depth-first walks
// ----------------------------------------------------------------------------
// Items are taken one at a time; in_stall is high from the transfer of an item
// until its last result has been loaded into the output register. Clear and
// rejected items go to their response; add edge reads the list of each vertex
// it updates, writes the new entry and links it to the old tail of a non-empty
// list. A walk follows adjacency entries by dependent next-link reads through
// the single read port of the entry memory, in breadth-first or depth-first
// order, then reads back the visit order. Reset needs no clearing pass.
// ----------------------------------------------------------------------------
module graph_bfs_dfs_traversal (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [gbt_pkg::MODE_W-1:0] in_mode,
  input  logic [gbt_pkg::VTX_W-1:0]  in_first_vertex,
  input  logic [gbt_pkg::VTX_W-1:0]  in_second_vertex,
  input  logic                       in_both_ways,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [gbt_pkg::VTX_W-1:0]  out_vertex,
  output logic [gbt_pkg::ST_W-1:0]   out_status,
  output logic                       out_last,
  input  logic                       cfg_wr_en,
  input  logic [gbt_pkg::CFG_W-1:0]  cfg_wr_data
);

  localparam int VW = gbt_pkg::VIDX_W;
  localparam int CW = gbt_pkg::CNT_W;
  localparam int EI = gbt_pkg::EIDX_W;
  localparam int EP = gbt_pkg::EPTR_W;

  typedef enum logic [16:0] {
    S_IDLE   = 17'b00000000000000001,
    S_RESP   = 17'b00000000000000010,
    S_ADD_RD = 17'b00000000000000100,
    S_ADD_WR = 17'b00000000000001000,
    S_ADD_LK = 17'b00000000000010000,
    S_BQ_RD  = 17'b00000000000100000,
    S_BQ_F   = 17'b00000000001000000,
    S_BL     = 17'b00000000010000000,
    S_BE     = 17'b00000000100000000,
    S_BN     = 17'b00000001000000000,
    S_DS_L   = 17'b00000010000000000,
    S_D_TOP  = 17'b00000100000000000,
    S_D_P    = 17'b00001000000000000,
    S_D_N    = 17'b00010000000000000,
    S_D_PUSH = 17'b00100000000000000,
    S_E_RD   = 17'b01000000000000000,
    S_E_OUT  = 17'b10000000000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [gbt_pkg::CFG_W-1:0]  vcount_r;
  logic [CW-1:0]              cnt;
  logic [gbt_pkg::MAX_VERTICES-1:0] lvld_r, lvld_nxt;
  logic [gbt_pkg::MAX_VERTICES-1:0] vis_r, vis_nxt;
  logic                       lhit_r, lhit_nxt;
  logic [EP-1:0]              used_r, used_nxt;
  logic [CW-1:0]              rd_r, rd_nxt, wr_r, wr_nxt, top_r, top_nxt, idx_r, idx_nxt;
  logic                       phase_r, phase_nxt;

  logic [VW-1:0]              a_r, a_nxt, b_r, b_nxt;
  logic                       both_r, both_nxt;
  logic [gbt_pkg::ST_W-1:0]   status_r, status_nxt;
  logic [EP-1:0]              p_r, p_nxt, e_r, e_nxt, tail_r, tail_nxt;

  logic              list_we, list_re;
  logic [VW-1:0]     list_wa, list_ra;
  logic [2*EP-1:0]   list_wd, list_rd;
  logic              nb_we, nx_we, ent_re;
  logic [EI-1:0]     nb_wa, nx_wa, ent_ra;
  logic [VW-1:0]     nb_wd, nb_rd;
  logic [EP-1:0]     nx_wd, nx_rd;
  logic              ord_we, ord_re;
  logic [VW-1:0]     ord_wa, ord_ra, ord_wd, ord_rd;
  logic              stk_we, stk_re;
  logic [VW-1:0]     stk_wa, stk_ra;
  logic [EP-1:0]     stk_wd, stk_rd;

  logic              push, can_push;
  gbt_pkg::res_t     res;

  logic              accept;
  logic [EP-1:0]     headp, free_cnt, need;
  logic [VW-1:0]     cur_v, cur_n;
  logic [CW-1:0]     top_m1;
  logic              take;

  assign cnt = (vcount_r > gbt_pkg::CFG_W'(gbt_pkg::MAX_VERTICES)) ?
               CW'(gbt_pkg::MAX_VERTICES) : CW'(vcount_r);
  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign headp    = lhit_r ? list_rd[2*EP-1:EP] : gbt_pkg::NO_ENTRY;
  assign free_cnt = gbt_pkg::NO_ENTRY - used_r;
  assign need     = in_both_ways ? EP'(2) : EP'(1);
  assign cur_v    = phase_r ? b_r : a_r;
  assign cur_n    = phase_r ? a_r : b_r;
  assign top_m1   = top_r - CW'(1);
  assign take     = ({1'b0, nb_rd} < cnt) && !vis_r[nb_rd];

  always_comb begin
    state_nxt  = state_r;
    lvld_nxt   = lvld_r;
    vis_nxt    = vis_r;
    used_nxt   = used_r;
    rd_nxt     = rd_r;
    wr_nxt     = wr_r;
    top_nxt    = top_r;
    idx_nxt    = idx_r;
    phase_nxt  = phase_r;
    a_nxt      = a_r;
    b_nxt      = b_r;
    both_nxt   = both_r;
    status_nxt = status_r;
    p_nxt      = p_r;
    e_nxt      = e_r;
    tail_nxt   = tail_r;
    list_we = 1'b0; list_wa = cur_v; list_wd = '0;
    list_re = 1'b0; list_ra = cur_v;
    nb_we = 1'b0; nb_wa = used_r[EI-1:0]; nb_wd = cur_n;
    nx_we = 1'b0; nx_wa = used_r[EI-1:0]; nx_wd = gbt_pkg::NO_ENTRY;
    ent_re = 1'b0; ent_ra = p_r[EI-1:0];
    ord_we = 1'b0; ord_wa = wr_r[VW-1:0]; ord_wd = nb_rd;
    ord_re = 1'b0; ord_ra = rd_r[VW-1:0];
    stk_we = 1'b0; stk_wa = top_m1[VW-1:0]; stk_wd = nx_rd;
    stk_re = 1'b0; stk_ra = top_m1[VW-1:0];
    push = 1'b0;
    res  = '0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          a_nxt    = in_first_vertex;
          b_nxt    = in_second_vertex;
          both_nxt = in_both_ways;
          phase_nxt = 1'b0;
          case (gbt_pkg::mode_t'(in_mode))
            gbt_pkg::MODE_ADD: begin
              if (({1'b0, in_first_vertex} >= cnt) || ({1'b0, in_second_vertex} >= cnt)) begin
                status_nxt = gbt_pkg::ST_BAD;
                state_nxt  = S_RESP;
              end else if (free_cnt < need) begin
                status_nxt = gbt_pkg::ST_FULL;
                state_nxt  = S_RESP;
              end else begin
                state_nxt = S_ADD_RD;
              end
            end
            gbt_pkg::MODE_CLR: begin
              lvld_nxt   = '0;
              used_nxt   = '0;
              status_nxt = gbt_pkg::ST_OK;
              state_nxt  = S_RESP;
            end
            default: begin
              if ({1'b0, in_first_vertex} >= cnt) begin
                status_nxt = gbt_pkg::ST_BAD;
                state_nxt  = S_RESP;
              end else begin
                vis_nxt = '0;
                vis_nxt[in_first_vertex] = 1'b1;
                ord_we = 1'b1;
                ord_wa = '0;
                ord_wd = in_first_vertex;
                wr_nxt = CW'(1);
                rd_nxt = '0;
                if (gbt_pkg::mode_t'(in_mode) == gbt_pkg::MODE_BFS) begin
                  state_nxt = S_BQ_RD;
                end else begin
                  list_re   = 1'b1;
                  list_ra   = in_first_vertex;
                  state_nxt = S_DS_L;
                end
              end
            end
          endcase
        end
      end
      S_RESP: begin
        if (can_push) begin
          push       = 1'b1;
          res.status = status_r;
          res.last   = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_ADD_RD: begin
        list_re   = 1'b1;
        state_nxt = S_ADD_WR;
      end
      S_ADD_WR: begin
        nb_we   = 1'b1;
        nx_we   = 1'b1;
        list_we = 1'b1;
        list_wd = {(lhit_r ? list_rd[2*EP-1:EP] : used_r), used_r};
        lvld_nxt[cur_v] = 1'b1;
        used_nxt = used_r + EP'(1);
        e_nxt    = used_r;
        tail_nxt = list_rd[EP-1:0];
        if (lhit_r) begin
          state_nxt = S_ADD_LK;
        end else if (!phase_r && both_r) begin
          phase_nxt = 1'b1;
          state_nxt = S_ADD_RD;
        end else begin
          status_nxt = gbt_pkg::ST_OK;
          state_nxt  = S_RESP;
        end
      end
      S_ADD_LK: begin
        nx_we = 1'b1;
        nx_wa = tail_r[EI-1:0];
        nx_wd = e_r;
        if (!phase_r && both_r) begin
          phase_nxt = 1'b1;
          state_nxt = S_ADD_RD;
        end else begin
          status_nxt = gbt_pkg::ST_OK;
          state_nxt  = S_RESP;
        end
      end
      S_BQ_RD: begin
        if (rd_r < wr_r) begin
          ord_re    = 1'b1;
          rd_nxt    = rd_r + CW'(1);
          state_nxt = S_BQ_F;
        end else begin
          idx_nxt   = '0;
          state_nxt = S_E_RD;
        end
      end
      S_BQ_F: begin
        list_re   = 1'b1;
        list_ra   = ord_rd;
        state_nxt = S_BL;
      end
      S_BL: begin
        p_nxt     = headp;
        state_nxt = S_BE;
      end
      S_BE: begin
        if (gbt_pkg::is_null(p_r)) begin
          state_nxt = S_BQ_RD;
        end else begin
          ent_re    = 1'b1;
          state_nxt = S_BN;
        end
      end
      S_BN: begin
        p_nxt = nx_rd;
        if (take && (wr_r < CW'(gbt_pkg::MAX_VERTICES))) begin
          vis_nxt[nb_rd] = 1'b1;
          ord_we = 1'b1;
          wr_nxt = wr_r + CW'(1);
        end
        state_nxt = S_BE;
      end
      S_DS_L: begin
        stk_we    = 1'b1;
        stk_wa    = '0;
        stk_wd    = headp;
        top_nxt   = CW'(1);
        state_nxt = S_D_TOP;
      end
      S_D_TOP: begin
        if (top_r == '0) begin
          idx_nxt   = '0;
          state_nxt = S_E_RD;
        end else begin
          stk_re    = 1'b1;
          state_nxt = S_D_P;
        end
      end
      S_D_P: begin
        p_nxt = stk_rd;
        if (gbt_pkg::is_null(stk_rd)) begin
          top_nxt   = top_m1;
          state_nxt = S_D_TOP;
        end else begin
          ent_re    = 1'b1;
          ent_ra    = stk_rd[EI-1:0];
          state_nxt = S_D_N;
        end
      end
      S_D_N: begin
        stk_we = 1'b1;
        if (take && (top_r < CW'(gbt_pkg::MAX_VERTICES))) begin
          vis_nxt[nb_rd] = 1'b1;
          ord_we    = 1'b1;
          wr_nxt    = wr_r + CW'(1);
          list_re   = 1'b1;
          list_ra   = nb_rd;
          state_nxt = S_D_PUSH;
        end else begin
          state_nxt = S_D_TOP;
        end
      end
      S_D_PUSH: begin
        stk_we    = 1'b1;
        stk_wa    = top_r[VW-1:0];
        stk_wd    = headp;
        top_nxt   = top_r + CW'(1);
        state_nxt = S_D_TOP;
      end
      S_E_RD: begin
        ord_re    = 1'b1;
        ord_ra    = idx_r[VW-1:0];
        state_nxt = S_E_OUT;
      end
      S_E_OUT: begin
        if (can_push) begin
          push       = 1'b1;
          res.vertex = ord_rd;
          res.status = gbt_pkg::ST_OK;
          res.last   = ((idx_r + CW'(1)) == wr_r);
          idx_nxt    = idx_r + CW'(1);
          state_nxt  = res.last ? S_IDLE : S_E_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign lhit_nxt = list_re ? lvld_r[list_ra] : lhit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      vcount_r <= gbt_pkg::COUNT_RESET;
      lvld_r   <= '0;
      vis_r    <= '0;
      lhit_r   <= 1'b0;
      used_r   <= '0;
      rd_r     <= '0;
      wr_r     <= '0;
      top_r    <= '0;
      idx_r    <= '0;
      phase_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      if (cfg_wr_en) begin
        vcount_r <= cfg_wr_data;
      end
      lvld_r   <= lvld_nxt;
      vis_r    <= vis_nxt;
      lhit_r   <= lhit_nxt;
      used_r   <= used_nxt;
      rd_r     <= rd_nxt;
      wr_r     <= wr_nxt;
      top_r    <= top_nxt;
      idx_r    <= idx_nxt;
      phase_r  <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r      <= a_nxt;
    b_r      <= b_nxt;
    both_r   <= both_nxt;
    status_r <= status_nxt;
    p_r      <= p_nxt;
    e_r      <= e_nxt;
    tail_r   <= tail_nxt;
  end

  gbt_ram #(.AW(VW), .DW(2*EP)) u_list (
    .clk(clk), .we(list_we), .wa(list_wa), .wd(list_wd),
    .re(list_re), .ra(list_ra), .rd(list_rd)
  );

  gbt_ram #(.AW(EI), .DW(VW)) u_nbr (
    .clk(clk), .we(nb_we), .wa(nb_wa), .wd(nb_wd),
    .re(ent_re), .ra(ent_ra), .rd(nb_rd)
  );

  gbt_ram #(.AW(EI), .DW(EP)) u_next (
    .clk(clk), .we(nx_we), .wa(nx_wa), .wd(nx_wd),
    .re(ent_re), .ra(ent_ra), .rd(nx_rd)
  );

  gbt_ram #(.AW(VW), .DW(VW)) u_order (
    .clk(clk), .we(ord_we), .wa(ord_wa), .wd(ord_wd),
    .re(ord_re), .ra(ord_ra), .rd(ord_rd)
  );

  gbt_ram #(.AW(VW), .DW(EP)) u_stack (
    .clk(clk), .we(stk_we), .wa(stk_wa), .wd(stk_wd),
    .re(stk_re), .ra(stk_ra), .rd(stk_rd)
  );

  gbt_out_stage u_out (
    .clk(clk), .rst_n(rst_n), .push(push), .res(res), .can_push(can_push),
    .out_valid(out_valid), .out_stall(out_stall), .out_vertex(out_vertex),
    .out_status(out_status), .out_last(out_last)
  );

endmodule

@@ design/gbt_ram.sv @@
// ----------------------------------------------------------------------------
// gbt_ram
// single-port-write, single-port-read synchronous ram, registered read data
// ----------------------------------------------------------------------------
module gbt_ram #(
  parameter int AW = 6,
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] wa,
  input  logic [DW-1:0] wd,
  input  logic          re,
  input  logic [AW-1:0] ra,
  output logic [DW-1:0] rd
);

  logic [DW-1:0] mem [2**AW];
  logic [DW-1:0] rd_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rd_r <= mem[ra];
    end
  end

  assign rd = rd_r;

endmodule

@@ design/gbt_out_stage.sv @@
// ----------------------------------------------------------------------------
// gbt_out_stage
// result output register with valid/stall handshake
// ----------------------------------------------------------------------------
module gbt_out_stage (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push,
  input  gbt_pkg::res_t            res,
  output logic                     can_push,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [gbt_pkg::VTX_W-1:0] out_vertex,
  output logic [gbt_pkg::ST_W-1:0]  out_status,
  output logic                     out_last
);

  logic          valid_r;
  gbt_pkg::res_t data_r;

  assign can_push = !valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (push) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      data_r <= res;
    end
  end

  assign out_valid  = valid_r;
  assign out_vertex = data_r.vertex;
  assign out_status = data_r.status;
  assign out_last   = data_r.last;

endmodule

@@ design/gbt_checker.sv @@
// ----------------------------------------------------------------------------
// gbt_checker
// port-level checks of the graph traversal block, bound to the top level
// ----------------------------------------------------------------------------
`include "graph_bfs_dfs_traversal_defines.svh"

module gbt_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [gbt_pkg::VTX_W-1:0]  out_vertex,
  input logic [gbt_pkg::ST_W-1:0]   out_status,
  input logic                       out_last
);

  // a held result stays offered
  `GBT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)

  // one item at a time: busy right after an input transfer
  `GBT_ASSERT_NEXT(a_busy_after_in, in_valid && !in_stall, in_stall)

  // error results are single and final
  `GBT_ASSERT_NOW(a_err_last, out_valid && (out_status != gbt_pkg::ST_OK), out_last)

  // error results carry vertex zero
  `GBT_ASSERT_NOW(a_err_zero, out_valid && (out_status != gbt_pkg::ST_OK), out_vertex == '0)

endmodule

bind graph_bfs_dfs_traversal gbt_checker u_gbt_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_vertex(out_vertex),
  .out_status(out_status), .out_last(out_last)
);
